### hw/rtl/dsu_pkg.sv
// ----------------------------------------------------------------------------
// dsu_pkg
// Shared types and constants of the disjoint-set union engine: field widths,
// controller states and the command / status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package dsu_pkg;

    localparam int IDX_W    = 10;            // node index field width
    localparam int CNT_W    = 11;            // count / size field width
    localparam int NODE_CAP = 1 << IDX_W;    // highest node count an index can reach

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_COMP,
        ST_COMP_W,
        ST_START_B,
        ST_SIZE_A,
        ST_SIZE_B,
        ST_SIZE_SUM,
        ST_DONE
    } dsu_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_step;     // write one clear entry, advance sweep
        logic accept;       // take input beat, start find of node_a
        logic walk_step;    // follow one parent link
        logic comp_issue;   // read parent of current path node
        logic comp_step;    // repoint current path node at root
        logic find_done;    // capture root of the current find
        logic start_b;      // start find of node_b
        logic size_a;       // read size of root a, link roots on a union
        logic size_b;       // capture size of root a, read size of root b
        logic size_sum;     // add sizes, write back
        logic load_out;     // load output register
    } dsu_ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic cfg_wr;       // node_count write this cycle
        logic in_bad;       // input beat carries an out-of-range index
        logic clr_last;     // clear sweep at its last entry
        logic hit;          // parent read back equals the node it belongs to
        logic at_root;      // current path node is the root
        logic next_root;    // parent read back is the root
        logic phase_b;      // working on node_b
        logic out_free;     // output register can take a result
    } dsu_stat_t;

endpackage

### hw/rtl/dsu_ram.sv
// ----------------------------------------------------------------------------
// dsu_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data (old data on a same-address read and write).
// ----------------------------------------------------------------------------
module dsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/dsu_ctrl.sv
// ----------------------------------------------------------------------------
// dsu_ctrl
// Controller of the union-find engine: sequences clear sweep, the two finds
// with path compression, the size update and the result hand-off.
// ----------------------------------------------------------------------------
module dsu_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  dsu_pkg::dsu_stat_t stat,
    output dsu_pkg::dsu_ctl_t  ctl
);

    import dsu_pkg::*;

    dsu_state_t state_reg;
    dsu_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_stall   = (state_reg != ST_IDLE) || stat.cfg_wr;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && !stat.cfg_wr)
                begin
                    ctl.accept = 1'b1;
                    state_next = stat.in_bad ? ST_DONE : ST_WALK;
                end
            end
            ST_WALK:
            begin
                ctl.walk_step = 1'b1;
                if (stat.hit)
                begin
                    state_next = ST_COMP;
                end
            end
            ST_COMP:
            begin
                if (stat.at_root)
                begin
                    ctl.find_done = 1'b1;
                    state_next    = stat.phase_b ? ST_SIZE_A : ST_START_B;
                end
                else
                begin
                    ctl.comp_issue = 1'b1;
                    state_next     = ST_COMP_W;
                end
            end
            ST_COMP_W:
            begin
                ctl.comp_step = 1'b1;
                if (stat.next_root)
                begin
                    ctl.find_done = 1'b1;
                    state_next    = stat.phase_b ? ST_SIZE_A : ST_START_B;
                end
            end
            ST_START_B:
            begin
                ctl.start_b = 1'b1;
                state_next  = ST_WALK;
            end
            ST_SIZE_A:
            begin
                ctl.size_a = 1'b1;
                state_next = ST_SIZE_B;
            end
            ST_SIZE_B:
            begin
                ctl.size_b = 1'b1;
                state_next = ST_SIZE_SUM;
            end
            ST_SIZE_SUM:
            begin
                ctl.size_sum = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        // a node_count write restarts the forest
        if (stat.cfg_wr)
        begin
            state_next = ST_CLEAR;
        end
    end

endmodule

### hw/rtl/dsu_datapath.sv
// ----------------------------------------------------------------------------
// dsu_datapath
// Datapath of the union-find engine: parent and size memories, walk and
// compression registers, node count, merge counter and output register.
// ----------------------------------------------------------------------------
module dsu_datapath #(
    parameter int MAX_NODES = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dsu_pkg::dsu_ctl_t          ctl,
    output dsu_pkg::dsu_stat_t         stat,
    input  logic                       cmd,
    input  logic [dsu_pkg::IDX_W-1:0]  node_a,
    input  logic [dsu_pkg::IDX_W-1:0]  node_b,
    input  logic                       cfg_valid,
    input  logic [dsu_pkg::CNT_W-1:0]  node_count,
    input  logic                       out_stall,
    output logic                       out_valid,
    output logic [dsu_pkg::IDX_W-1:0]  root_a,
    output logic [dsu_pkg::IDX_W-1:0]  root_b,
    output logic                       same_set,
    output logic [dsu_pkg::CNT_W-1:0]  size_a,
    output logic                       merged,
    output logic [dsu_pkg::CNT_W-1:0]  set_count,
    output logic                       bad_index
);

    import dsu_pkg::*;

    localparam int DEPTH = (MAX_NODES < NODE_CAP) ? MAX_NODES : NODE_CAP;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] NODE_LIMIT = CNT_W'(DEPTH);
    localparam logic [AW-1:0]    LAST_ADDR  = AW'(DEPTH - 1);

    // control state
    logic [CNT_W-1:0] node_count_reg;
    logic [IDX_W-1:0] merge_cnt_reg;
    logic [AW-1:0]    clr_addr_reg;
    logic             out_valid_reg;

    // item registers
    logic [AW-1:0]    a_reg;
    logic [AW-1:0]    b_reg;
    logic [AW-1:0]    cur_reg;
    logic [AW-1:0]    root_reg;
    logic [AW-1:0]    ra_reg;
    logic [AW-1:0]    rb_reg;
    logic             cmd_reg;
    logic             bad_reg;
    logic             phase_reg;
    logic             merge_reg;
    logic [CNT_W-1:0] size_ra_reg;
    logic [CNT_W-1:0] size_res_reg;

    // output register
    logic [IDX_W-1:0] root_a_reg;
    logic [IDX_W-1:0] root_b_reg;
    logic             same_set_reg;
    logic [CNT_W-1:0] size_a_reg;
    logic             merged_reg;
    logic [CNT_W-1:0] set_count_reg;
    logic             bad_index_reg;

    // memory ports
    logic             p_we;
    logic [AW-1:0]    p_waddr;
    logic [AW-1:0]    p_wdata;
    logic [AW-1:0]    p_raddr;
    logic [AW-1:0]    p_rdata;
    logic             s_we;
    logic [AW-1:0]    s_waddr;
    logic [CNT_W-1:0] s_wdata;
    logic [AW-1:0]    s_raddr;
    logic [CNT_W-1:0] s_rdata;

    logic             in_bad;
    logic             merge_now;
    logic [CNT_W-1:0] cfg_clamped;
    logic [CNT_W-1:0] size_sum;

    assign in_bad = ({1'b0, node_a} >= node_count_reg) || ({1'b0, node_b} >= node_count_reg);
    assign merge_now = !cmd_reg && (ra_reg != rb_reg);
    assign size_sum  = size_ra_reg + s_rdata;

    always_comb
    begin
        priority if (node_count == '0)
        begin
            cfg_clamped = CNT_W'(1);
        end
        else if (node_count > NODE_LIMIT)
        begin
            cfg_clamped = NODE_LIMIT;
        end
        else
        begin
            cfg_clamped = node_count;
        end
    end

    // parent memory addressing
    always_comb
    begin
        priority if (ctl.accept)
        begin
            p_raddr = node_a[AW-1:0];
        end
        else if (ctl.start_b)
        begin
            p_raddr = b_reg;
        end
        else if (ctl.comp_issue)
        begin
            p_raddr = cur_reg;
        end
        else
        begin
            p_raddr = p_rdata;
        end

        p_we    = 1'b0;
        p_waddr = clr_addr_reg;
        p_wdata = clr_addr_reg;
        priority if (ctl.clr_step)
        begin
            p_we = 1'b1;
        end
        else if (ctl.comp_step)
        begin
            p_we    = 1'b1;
            p_waddr = cur_reg;
            p_wdata = root_reg;
        end
        else if (ctl.size_a && merge_now)
        begin
            p_we    = 1'b1;
            p_waddr = ra_reg;
            p_wdata = rb_reg;
        end
        else
        begin
            p_we = 1'b0;
        end
    end

    // size memory addressing
    always_comb
    begin
        s_raddr = ctl.size_a ? ra_reg : rb_reg;
        s_we    = 1'b0;
        s_waddr = clr_addr_reg;
        s_wdata = CNT_W'(1);
        priority if (ctl.clr_step)
        begin
            s_we = 1'b1;
        end
        else if (ctl.size_sum && merge_reg)
        begin
            s_we    = 1'b1;
            s_waddr = rb_reg;
            s_wdata = size_sum;
        end
        else
        begin
            s_we = 1'b0;
        end
    end

    dsu_ram #(
        .WIDTH (AW),
        .DEPTH (DEPTH)
    ) u_parent_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    dsu_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH)
    ) u_size_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_LIMIT;
            merge_cnt_reg  <= '0;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                node_count_reg <= cfg_clamped;
                merge_cnt_reg  <= '0;
                clr_addr_reg   <= '0;
            end
            else
            begin
                if (ctl.clr_step)
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                end
                if (ctl.size_a && merge_now)
                begin
                    merge_cnt_reg <= merge_cnt_reg + IDX_W'(1);
                end
            end

            if (ctl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item and output payload
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            a_reg     <= node_a[AW-1:0];
            b_reg     <= node_b[AW-1:0];
            cur_reg   <= node_a[AW-1:0];
            cmd_reg   <= cmd;
            bad_reg   <= in_bad;
            phase_reg <= 1'b0;
        end
        if (ctl.walk_step)
        begin
            if (p_rdata == cur_reg)
            begin
                root_reg <= cur_reg;
                cur_reg  <= phase_reg ? b_reg : a_reg;
            end
            else
            begin
                cur_reg <= p_rdata;
            end
        end
        if (ctl.comp_step)
        begin
            cur_reg <= p_rdata;
        end
        if (ctl.find_done)
        begin
            if (phase_reg)
            begin
                rb_reg <= root_reg;
            end
            else
            begin
                ra_reg <= root_reg;
            end
        end
        if (ctl.start_b)
        begin
            cur_reg   <= b_reg;
            phase_reg <= 1'b1;
        end
        if (ctl.size_a)
        begin
            merge_reg <= merge_now;
        end
        if (ctl.size_b)
        begin
            size_ra_reg <= s_rdata;
        end
        if (ctl.size_sum)
        begin
            size_res_reg <= merge_reg ? size_sum : size_ra_reg;
        end
        if (ctl.load_out)
        begin
            root_a_reg    <= bad_reg ? '0 : IDX_W'(merge_reg ? rb_reg : ra_reg);
            root_b_reg    <= bad_reg ? '0 : IDX_W'(rb_reg);
            same_set_reg  <= !bad_reg && (merge_reg || (ra_reg == rb_reg));
            size_a_reg    <= bad_reg ? '0 : size_res_reg;
            merged_reg    <= !bad_reg && merge_reg;
            set_count_reg <= node_count_reg - CNT_W'(merge_cnt_reg);
            bad_index_reg <= bad_reg;
        end
    end

    assign stat.cfg_wr    = cfg_valid;
    assign stat.in_bad    = in_bad;
    assign stat.clr_last  = (clr_addr_reg == LAST_ADDR);
    assign stat.hit       = (p_rdata == cur_reg);
    assign stat.at_root   = (cur_reg == root_reg);
    assign stat.next_root = (p_rdata == root_reg);
    assign stat.phase_b   = phase_reg;
    assign stat.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign root_a    = root_a_reg;
    assign root_b    = root_b_reg;
    assign same_set  = same_set_reg;
    assign size_a    = size_a_reg;
    assign merged    = merged_reg;
    assign set_count = set_count_reg;
    assign bad_index = bad_index_reg;

endmodule

### hw/rtl/disjoint_set_union_engine_top.sv
// ----------------------------------------------------------------------------
// disjoint_set_union_engine_top
// Union-find engine with path compression over an on-chip parent table and
// set-size table; one result beat per input beat.
// ----------------------------------------------------------------------------
// Each input beat either unites the sets of node_a and node_b (cmd 0) or only
// queries them (cmd 1); the engine handles one beat at a time and returns one
// result beat for it. A beat runs through the parent-memory walk: one parent
// read per hop to find the root, then one read and one write per hop to point
// every node on the path straight at the root, once for each node, followed
// by the size-memory read and update in ST_SIZE_A, ST_SIZE_B and ST_SIZE_SUM.
// Compression keeps trees flat; a beat with an index at or above node_count
// skips the walk and changes nothing. The result sits in an output register,
// so the next beat is taken while a finished result waits. After reset and
// after every node_count write the engine rebuilds a fresh forest with a
// clearing sweep over min(MAX_NODES, 1024) entries, one entry of each table
// per cycle, during which in_stall stays high. The user must write node_count
// only while the engine is idle; the block itself does not enforce it.
// cfg_ready is always high.
module disjoint_set_union_engine_top #(
    parameter int MAX_NODES = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [dsu_pkg::CNT_W-1:0]  node_count,
    // input beats
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       cmd,
    input  logic [dsu_pkg::IDX_W-1:0]  node_a,
    input  logic [dsu_pkg::IDX_W-1:0]  node_b,
    // result beats
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [dsu_pkg::IDX_W-1:0]  root_a,
    output logic [dsu_pkg::IDX_W-1:0]  root_b,
    output logic                       same_set,
    output logic [dsu_pkg::CNT_W-1:0]  size_a,
    output logic                       merged,
    output logic [dsu_pkg::CNT_W-1:0]  set_count,
    output logic                       bad_index
);

    import dsu_pkg::*;

    dsu_ctl_t  ctl;
    dsu_stat_t stat;

    // configuration writes always land; a write restarts the clear sweep
    assign cfg_ready = 1'b1;

    dsu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctl      (ctl)
    );

    dsu_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .stat       (stat),
        .cmd        (cmd),
        .node_a     (node_a),
        .node_b     (node_b),
        .cfg_valid  (cfg_valid),
        .node_count (node_count),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .root_a     (root_a),
        .root_b     (root_b),
        .same_set   (same_set),
        .size_a     (size_a),
        .merged     (merged),
        .set_count  (set_count),
        .bad_index  (bad_index)
    );

endmodule

### hw/rtl/dsu_checker.sv
// ----------------------------------------------------------------------------
// dsu_checker
// Port-level checks of the union-find engine, bound to the top level.
// ----------------------------------------------------------------------------
module dsu_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [dsu_pkg::IDX_W-1:0]  root_a,
    input logic [dsu_pkg::IDX_W-1:0]  root_b,
    input logic                       same_set,
    input logic [dsu_pkg::CNT_W-1:0]  size_a,
    input logic                       merged,
    input logic [dsu_pkg::CNT_W-1:0]  set_count,
    input logic                       bad_index
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(root_a) && $stable(root_b)
            && $stable(size_a) && $stable(set_count) && $stable(merged))
        else $error("result beat changed while stalled");

    // a flagged beat reports nothing but the count
    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_index |-> !merged && !same_set && (size_a == '0)
            && (root_a == '0) && (root_b == '0))
        else $error("flagged beat carries result data");

    // a merge leaves both nodes under one root
    a_merge_same: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && merged |-> same_set && (root_a == root_b) && (size_a > 'd1))
        else $error("merge without common root");

    // sets are never empty, and at least one set exists
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bad_index |-> (size_a != '0) && (set_count != '0))
        else $error("empty set size or set count");

endmodule

bind disjoint_set_union_engine_top dsu_checker u_dsu_checker (.*);

### tb/tb_disjoint_set_union_engine_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_disjoint_set_union_engine_top
// Self-checking bench for the union-find engine. A scoreboard class keeps
// its own copy of the parent table, the set-size table and the merge count.
// For every accepted request beat it works out the expected answer, and it
// compares each result beat with the oldest answer still waiting. Short
// directed passes are followed by random phases under several forest sizes and
// several idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb_disjoint_set_union_engine_top;

    import dsu_pkg::*;

    // Request opcodes carried on cmd
    localparam logic CMD_UNITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Cycles with no beat on any channel before the run is declared hung.
    // Covers a full clearing sweep plus the deepest possible walk, many times.
    localparam int WATCHDOG_LIMIT = 20000;
    // Cycles to keep watching the result channel once all answers are in
    localparam int TAIL_CYCLES    = 40;
    localparam int RANDOM_PER_PHASE = 160;

    // One expected or observed result beat
    typedef struct packed {
        logic [IDX_W-1:0] root_a;
        logic [IDX_W-1:0] root_b;
        logic             same_set;
        logic [CNT_W-1:0] size_a;
        logic             merged;
        logic [CNT_W-1:0] set_count;
        logic             bad_index;
    } dsu_answer_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the forest and queues the answers it predicts
    // ------------------------------------------------------------------------
    class forest_scoreboard;
        logic [IDX_W-1:0] parent_tbl [NODE_CAP];
        logic [CNT_W-1:0] size_tbl   [NODE_CAP];
        logic [IDX_W-1:0] merge_total;
        logic [CNT_W-1:0] nodes_in_use;
        dsu_answer_t      pending_answers [$];
        int               errors          = 0;
        int               answers_checked = 0;
        int               merges_seen     = 0;
        int               rejects_seen    = 0;
        int               queries_seen    = 0;

        function new();
            nodes_in_use = CNT_W'(NODE_CAP);
            clear_forest();
        endfunction

        function void clear_forest();
            for (int i = 0; i < NODE_CAP; i++)
            begin
                parent_tbl[i] = IDX_W'(i);
                size_tbl[i]   = CNT_W'(1);
            end
            merge_total = '0;
        endfunction

        // Clamp to 1..NODE_CAP; every write starts a fresh forest
        function void configure(logic [CNT_W-1:0] value);
            if (value < CNT_W'(1))
                nodes_in_use = CNT_W'(1);
            else if (value > CNT_W'(NODE_CAP))
                nodes_in_use = CNT_W'(NODE_CAP);
            else
                nodes_in_use = value;
            clear_forest();
        endfunction

        // Walk to the root, then repoint every node on the path at it
        function logic [IDX_W-1:0] find_root(logic [IDX_W-1:0] node);
            logic [IDX_W-1:0] root;
            logic [IDX_W-1:0] hop;
            int               steps;
            root  = node;
            steps = 0;
            while (parent_tbl[root] != root && steps < nodes_in_use)
            begin
                root = parent_tbl[root];
                steps++;
            end
            steps = 0;
            while (node != root && steps < nodes_in_use)
            begin
                hop              = parent_tbl[node];
                parent_tbl[node] = root;
                node             = hop;
                steps++;
            end
            return root;
        endfunction

        function void note_request(logic c, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
            dsu_answer_t      ans;
            logic [IDX_W-1:0] ra;
            logic [IDX_W-1:0] rb;
            ans = '0;
            if (a >= nodes_in_use || b >= nodes_in_use)
            begin
                ans.bad_index = 1'b1;
                rejects_seen++;
            end
            else
            begin
                ra = find_root(a);
                rb = find_root(b);
                if (c == CMD_UNITE && ra != rb)
                begin
                    parent_tbl[ra] = rb;
                    size_tbl[rb]   = size_tbl[rb] + size_tbl[ra];
                    merge_total    = merge_total + 1'b1;
                    ans.merged     = 1'b1;
                    ra             = rb;
                    merges_seen++;
                end
                if (c == CMD_QUERY)
                    queries_seen++;
                ans.root_a   = ra;
                ans.root_b   = rb;
                ans.same_set = (ra == rb);
                ans.size_a   = size_tbl[ra];
            end
            ans.set_count = nodes_in_use - CNT_W'(merge_total);
            pending_answers.push_back(ans);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_answer(dsu_answer_t got);
            dsu_answer_t want;
            if (pending_answers.size() == 0)
            begin
                $error("result beat arrived with no request outstanding");
                errors++;
                return;
            end
            want = pending_answers.pop_front();
            compare_field("root_a",    want.root_a,    got.root_a);
            compare_field("root_b",    want.root_b,    got.root_b);
            compare_field("same_set",  want.same_set,  got.same_set);
            compare_field("size_a",    want.size_a,    got.size_a);
            compare_field("merged",    want.merged,    got.merged);
            compare_field("set_count", want.set_count, got.set_count);
            compare_field("bad_index", want.bad_index, got.bad_index);
            answers_checked++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             cfg_valid  = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] node_count = '0;
    logic             in_valid   = 1'b0;
    logic             in_stall;
    logic             cmd        = CMD_UNITE;
    logic [IDX_W-1:0] node_a     = '0;
    logic [IDX_W-1:0] node_b     = '0;
    logic             out_valid;
    logic             out_stall  = 1'b0;
    logic [IDX_W-1:0] root_a;
    logic [IDX_W-1:0] root_b;
    logic             same_set;
    logic [CNT_W-1:0] size_a;
    logic             merged;
    logic [CNT_W-1:0] set_count;
    logic             bad_index;

    // Pacing knobs, in percent of cycles, then the watchdog and forest counters
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int idle_cycles    = 0;
    int forests_built  = 0;

    forest_scoreboard sb;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    disjoint_set_union_engine_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .node_count(node_count),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .node_a    (node_a),
        .node_b    (node_b),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .root_a    (root_a),
        .root_b    (root_b),
        .same_set  (same_set),
        .size_a    (size_a),
        .merged    (merged),
        .set_count (set_count),
        .bad_index (bad_index)
    );

    // ------------------------------------------------------------------------
    // Result side: check every accepted beat, then pick next cycle's stall.
    // Stall is drawn without looking at out_valid.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        dsu_answer_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {root_a, root_b, same_set, size_a, merged, set_count, bad_index};
            sb.check_answer(got);
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles with no beat on any channel
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : hang_watchdog
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles < WATCHDOG_LIMIT)
                idle_cycles <= idle_cycles + 1;
            else
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request driver. Called at a rising edge; holds the payload until the
    // beat is taken. Valid stays high across back-to-back beats.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic c, input logic [IDX_W-1:0] a,
                                input logic [IDX_W-1:0] b);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        node_a   <= a;
        node_b   <= b;
        do @(posedge clk); while (in_stall);
        sb.note_request(c, a, b);
    endtask

    // Drop valid and wait until every predicted answer has been checked
    task automatic drain_answers();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // Write node_count once the engine is idle; the write clears the forest
    task automatic write_node_count(input logic [CNT_W-1:0] value);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        cfg_valid  <= 1'b1;
        node_count <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.configure(value);
        forests_built++;
    endtask

    task automatic set_pacing(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Random phase: chained unions that grow deep trees, random
    // unions and queries, plus a share of out-of-range beats. Only in-range
    // beats count toward the target.
    // ------------------------------------------------------------------------
    task automatic run_random_phase(input int target);
        int               in_range_sent;
        int               pick;
        int               nc;
        int               chain;
        logic             c;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        nc            = sb.nodes_in_use;
        chain         = $urandom_range(nc - 1);
        in_range_sent = 0;
        while (in_range_sent < target)
        begin
            pick = $urandom_range(99);
            c    = CMD_UNITE;
            a    = IDX_W'($urandom_range(nc - 1));
            b    = IDX_W'($urandom_range(nc - 1));
            if (pick < 3)
                chain = $urandom_range(nc - 1);
            if (pick < 30)
            begin
                // hang the chain head under the next node, so trees get deep
                a     = IDX_W'(chain);
                chain = (chain + 1) % nc;
                b     = IDX_W'(chain);
            end
            else if (pick < 55)
                c = CMD_UNITE;
            else if (pick < 88)
                c = CMD_QUERY;
            else if (nc < NODE_CAP)
            begin
                c = logic'($urandom_range(1));
                case ($urandom_range(2))
                    0: a = IDX_W'($urandom_range(NODE_CAP - 1, nc));
                    1: b = IDX_W'($urandom_range(NODE_CAP - 1, nc));
                    default:
                    begin
                        a = IDX_W'($urandom_range(NODE_CAP - 1, nc));
                        b = IDX_W'($urandom_range(NODE_CAP - 1, nc));
                    end
                endcase
            end
            else
                c = CMD_QUERY;
            send_request(c, a, b);
            if (a < nc && b < nc)
                in_range_sent++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        logic [CNT_W-1:0] forest_sizes [11];
        forest_sizes = '{CNT_W'(16), CNT_W'(2047), CNT_W'(3), CNT_W'(1000), CNT_W'(0),
                         CNT_W'(1024), CNT_W'(128), CNT_W'(1500), CNT_W'(2),
                         CNT_W'(600), CNT_W'(1)};
        sb = new();

        // Hold reset low from time zero, release at an edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: full forest at its reset size, extreme indices
        set_pacing(0);
        send_request(CMD_UNITE, 10'd0,    10'd1023);
        send_request(CMD_QUERY, 10'd0,    10'd1023);
        send_request(CMD_UNITE, 10'd0,    10'd1023);   // same set, no merge
        send_request(CMD_UNITE, 10'd1023, 10'd512);
        send_request(CMD_QUERY, 10'd0,    10'd512);
        send_request(CMD_UNITE, 10'd341,  10'd682);
        send_request(CMD_UNITE, 10'd682,  10'd341);
        send_request(CMD_UNITE, 10'd5,    10'd5);      // node with itself
        send_request(CMD_QUERY, 10'd1023, 10'd1023);
        send_request(CMD_UNITE, 10'd682,  10'd0);
        send_request(CMD_QUERY, 10'd341,  10'd512);
        drain_answers();

        // Directed: small forest, out-of-range on either side and both
        write_node_count(CNT_W'(5));
        send_request(CMD_UNITE, 10'd4,    10'd0);
        send_request(CMD_UNITE, 10'd5,    10'd0);
        send_request(CMD_UNITE, 10'd0,    10'd5);
        send_request(CMD_QUERY, 10'd1023, 10'd1023);
        send_request(CMD_UNITE, 10'd3,    10'd4);
        send_request(CMD_UNITE, 10'd2,    10'd3);
        send_request(CMD_UNITE, 10'd1,    10'd2);
        send_request(CMD_QUERY, 10'd4,    10'd1);      // both nodes already hang straight under root 0
        drain_answers();

        // Directed: zero clamps to a single node
        write_node_count(CNT_W'(0));
        send_request(CMD_UNITE, 10'd0, 10'd0);
        send_request(CMD_QUERY, 10'd0, 10'd0);
        send_request(CMD_QUERY, 10'd1, 10'd0);
        drain_answers();

        // Directed: all-ones write clamps to the full table
        write_node_count(CNT_W'(2047));
        send_request(CMD_QUERY, 10'd1023, 10'd0);
        send_request(CMD_UNITE, 10'd1023, 10'd0);
        drain_answers();

        // Random phases: rotate forest size and pacing together
        forest_sizes[10] = CNT_W'($urandom_range(1, 2047));
        for (int p = 0; p < 11; p++)
        begin
            write_node_count(forest_sizes[p]);
            set_pacing(p);
            run_random_phase(RANDOM_PER_PHASE);
            drain_answers();
        end

        // Watch for stray result beats before closing out
        set_pacing(0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d result beats over %0d forest sizes under four pacing modes.",
                 sb.answers_checked, forests_built);
        $display("Saw %0d merges, %0d in-range queries and %0d out-of-range beats.",
                 sb.merges_seen, sb.queries_seen, sb.rejects_seen);
        if (sb.errors == 0 && sb.pending_answers.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
